>>> rtl/smx_pkg.sv
// shared constants, types and exp table builder for the softmax column unit
package smx_pkg;

  localparam int MAX_LEN        = 64;
  localparam int EXP_TABLE_SIZE = 1024;

  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int TAB_AW  = $clog2(EXP_TABLE_SIZE + 1);
  localparam int EXP_W   = 17;
  localparam int SUM_W   = EXP_W + $clog2(MAX_LEN);
  localparam int NUM_W   = 33;
  localparam int Q_W     = 17;
  localparam int QC_W    = $clog2(Q_W + 1);
  localparam int DOT_W   = 40;
  localparam int DIFF_W  = DOT_W + 1;
  localparam int LO_W    = 24;
  localparam int HI_W    = DIFF_W - LO_W;
  localparam int MA_W    = 18;
  localparam int MB_W    = LO_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int FULL_W  = PROD_W + LO_W + 1;
  localparam int SCL_W   = 15 + TAB_AW;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_SIZE];

  typedef enum logic [3:0] {
    S_LOAD, S_ACC,
    S_SRD, S_SEXP, S_SADD,
    S_PRD, S_PEXP, S_PST, S_PDIV,
    S_GRD, S_GLO, S_GHI, S_GFIN,
    S_OUT
  } smx_state_t;

  // exp(-16k/size) in q1.16, built by repeated multiplication by one step ratio
  function automatic exp_tab_t build_exp_tab();
    logic [63:0]  t;
    logic [63:0]  term;
    logic [63:0]  r;
    logic [63:0]  p;
    logic [127:0] w;
    logic [63:0]  e;
    exp_tab_t     tab;
    t    = (64'd16 << 32) / EXP_TABLE_SIZE;
    term = 64'd1 << 32;
    r    = term;
    p    = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      w    = 128'(term) * 128'(t);
      term = w[95:32] / 64'(n);
      if (n % 2 == 1) r = r - term;
      else            r = r + term;
    end
    for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
      e      = (p + 64'h8000) >> 16;
      tab[k] = e[EXP_W-1:0];
      w      = 128'(p) * 128'(r) + (128'd1 << 31);
      p      = w[95:32];
    end
    return tab;
  endfunction

endpackage

>>> rtl/smx_store.sv
// element stores: logit or probability, and upstream gradient
module smx_store import smx_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [15:0]      wdata_a,
  input  logic [15:0]      wdata_b,
  input  logic [IDX_W-1:0] raddr,
  output logic [15:0]      rdata_a,
  output logic [15:0]      rdata_b
);

  logic [15:0] mem_a [0:MAX_LEN-1];
  logic [15:0] mem_b [0:MAX_LEN-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata_a;
      mem_b[waddr] <= wdata_b;
    end
    rdata_a <= mem_a[raddr];
    rdata_b <= mem_b[raddr];
  end

endmodule

>>> rtl/smx_exp_rom.sv
// exp lookup table with registered read
module smx_exp_rom import smx_pkg::*; (
  input  logic              clk,
  input  logic [TAB_AW-1:0] addr,
  output logic [EXP_W-1:0]  data_r
);

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  always_ff @(posedge clk) begin
    data_r <= EXP_TAB[addr];
  end

endmodule

>>> rtl/smx_div.sv
// restoring divider, one quotient bit per cycle
module smx_div import smx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done_r,
  output logic [Q_W-1:0]   quo
);

  logic [SUM_W-1:0] rem_r;
  logic [SUM_W-1:0] den_r;
  logic [Q_W-1:0]   sh_r;
  logic [QC_W-1:0]  cnt_r;
  logic             busy_r;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, sh_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign quo   = sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= QC_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == QC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient fits in q_w bits, so the top part of the dividend starts below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SUM_W'(num[NUM_W-1:Q_W]);
      sh_r  <= num[Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      sh_r  <= {sh_r[Q_W-2:0], ge};
    end
  end

endmodule

>>> rtl/softmax_column_unit.sv
// softmax column unit: top level with sequencer and shared multiplier
// loading takes each element through S_LOAD and S_ACC; a column closes on tlast or at MAX_LEN elements
// forward: a sum pass per element (S_SRD, S_SEXP, S_SADD), then a result pass per element
//   (store read, exp lookup, bit-serial divider) plus any output wait
// backward: S_GRD, S_GLO, S_GHI and S_GFIN per element through the shared 18x25 multiplier, plus output wait
// reset clears control state only; the stores are not cleared and need no pass
module softmax_column_unit import smx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // logit, prob, upstream_grad
  input  logic        in_tuser,  // func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // out_prob, out_grad
  output logic        out_tlast
);

  smx_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       max_r, max_nxt;
  logic [DOT_W-1:0]  dot_r, dot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              mode_r, mode_nxt;
  logic              close_r, close_nxt;
  logic              zero_r, zero_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] lo_r, lo_nxt;
  logic [15:0]       oprob_r, oprob_nxt;
  logic [15:0]       ograd_r, ograd_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic [15:0]       v_in;
  logic [CNT_W-1:0]  cnt_inc;
  logic              is_last;
  logic [15:0]       mem_a, mem_b;
  logic [16:0]       dz, nd;
  logic              zflag;
  logic [SCL_W-1:0]  scaled;
  logic [TAB_AW-1:0] rom_addr;
  logic [EXP_W-1:0]  rom_data;
  logic [EXP_W-1:0]  e_val;
  logic [DIFF_W-1:0] diff;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] rnd;
  logic signed [FULL_W-33:0] g;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [Q_W-1:0]    div_q;

  assign in_tready  = (state_r == S_LOAD);
  assign accept     = in_tvalid && in_tready;
  assign v_in       = in_tuser ? in_tdata[31:16] : in_tdata[15:0];
  assign cnt_inc    = cnt_r + 1'b1;
  assign is_last    = (CNT_W'(idx_r) == cnt_r - 1'b1);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {ograd_r, oprob_r};
  assign out_tlast  = olast_r;

  smx_store u_store (
    .clk(clk), .we(accept), .waddr(cnt_r[IDX_W-1:0]),
    .wdata_a(v_in), .wdata_b(in_tdata[47:32]),
    .raddr(idx_r), .rdata_a(mem_a), .rdata_b(mem_b)
  );

  // exp argument: -(z - max), zero beyond sixteen
  assign dz       = {mem_a[15], mem_a} - {max_r[15], max_r};
  assign nd       = -dz;
  assign zflag    = nd > 17'd16384;
  assign scaled   = SCL_W'(nd[14:0]) * SCL_W'(EXP_TABLE_SIZE);
  assign rom_addr = scaled[14 +: TAB_AW];
  assign e_val    = zero_r ? '0 : rom_data;

  smx_exp_rom u_rom (.clk(clk), .addr(rom_addr), .data_r(rom_data));

  assign div_num   = {e_val, 16'd0} + NUM_W'(sum_r >> 1);
  assign div_start = (state_r == S_PST);

  smx_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(sum_r), .done_r(div_done), .quo(div_q)
  );

  // f * 65536 - dot, split into unsigned low and signed high parts for the multiplier
  assign diff = {{(DIFF_W-32){mem_b[15]}}, mem_b, 16'd0} - {dot_r[DOT_W-1], dot_r};

  always_comb begin
    unique case (state_r)
      S_LOAD: begin
        mul_a = MA_W'(v_in);
        mul_b = MB_W'($signed(in_tdata[47:32]));
      end
      S_GLO: begin
        mul_a = MA_W'(mem_a);
        mul_b = {1'b0, diff[LO_W-1:0]};
      end
      default: begin
        mul_a = MA_W'(mem_a);
        mul_b = MB_W'($signed(diff[DIFF_W-1:LO_W]));
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign full = (FULL_W'($signed(prod_r)) <<< LO_W) + FULL_W'($signed(lo_r));
  assign rnd  = full + (FULL_W'(1) <<< 31);
  assign g    = rnd[FULL_W-1:32];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    max_nxt   = max_r;
    dot_nxt   = dot_r;
    sum_nxt   = sum_r;
    mode_nxt  = mode_r;
    close_nxt = close_r;
    zero_nxt  = zero_r;
    prod_nxt  = prod_r;
    lo_nxt    = lo_r;
    oprob_nxt = oprob_r;
    ograd_nxt = ograd_r;
    olast_nxt = olast_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cnt_nxt   = cnt_inc;
          mode_nxt  = in_tuser;
          close_nxt = in_tlast || (cnt_inc == CNT_W'(MAX_LEN));
          prod_nxt  = mul_p;
          if ($signed(v_in) > $signed(max_r)) max_nxt = v_in;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        dot_nxt = dot_r + DOT_W'($signed(prod_r));
        if (close_r) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = mode_r ? S_GRD : S_SRD;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_SRD: state_nxt = S_SEXP;
      S_SEXP: begin
        zero_nxt  = zflag;
        state_nxt = S_SADD;
      end
      S_SADD: begin
        sum_nxt = sum_r + SUM_W'(e_val);
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = S_PRD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_PRD: state_nxt = S_PEXP;
      S_PEXP: begin
        zero_nxt  = zflag;
        state_nxt = S_PST;
      end
      S_PST: state_nxt = S_PDIV;
      S_PDIV: begin
        if (div_done) begin
          if (sum_r == '0)    oprob_nxt = '0;
          else if (div_q[16]) oprob_nxt = 16'hFFFF;
          else                oprob_nxt = div_q[15:0];
          ograd_nxt = '0;
          olast_nxt = is_last;
          state_nxt = S_OUT;
        end
      end
      S_GRD: state_nxt = S_GLO;
      S_GLO: begin
        prod_nxt  = mul_p;
        state_nxt = S_GHI;
      end
      S_GHI: begin
        lo_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_GFIN;
      end
      S_GFIN: begin
        if (g > $signed((FULL_W-32)'(32767)))       ograd_nxt = 16'h7FFF;
        else if (g < -$signed((FULL_W-32)'(32768))) ograd_nxt = 16'h8000;
        else                                        ograd_nxt = g[15:0];
        oprob_nxt = '0;
        olast_nxt = is_last;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (olast_r) begin
            cnt_nxt   = '0;
            max_nxt   = 16'h8000;
            dot_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = mode_r ? S_GRD : S_PRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      max_r   <= 16'h8000;
      dot_r   <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      mode_r  <= 1'b0;
      close_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      dot_r   <= dot_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
      mode_r  <= mode_nxt;
      close_r <= close_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r  <= zero_nxt;
    prod_r  <= prod_nxt;
    lo_r    <= lo_nxt;
    oprob_r <= oprob_nxt;
    ograd_r <= ograd_nxt;
    olast_r <= olast_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while a result waits");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN)) else $error("element count beyond column length");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && cnt_r == '0)
    else $error("column not released after final result");

  a_fwd_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !mode_r |-> out_tdata[31:16] == 16'd0)
    else $error("forward result carries a gradient");

endmodule

>>> test/tb_softmax_column_unit.sv
// testbench for the softmax column unit: directed and random columns checked against a predictor
module tb_softmax_column_unit;
  import smx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_FWD = 1'b0;
  localparam logic FUNC_BWD = 1'b1;

  typedef struct packed {
    logic [15:0] prob;
    logic [15:0] grad;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  softmax_column_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // predictor state
  logic [16:0]        exp_lut [0:EXP_TABLE_SIZE];
  logic [15:0]        col_val [0:MAX_LEN-1];
  logic [15:0]        col_grad [0:MAX_LEN-1];
  int                 col_len;
  logic signed [15:0] col_max;
  logic signed [63:0] col_dot;

  result_t expected_q[$];
  int      error_count;
  bit      sink_idle;
  bit      src_idle;
  int      hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic build_exp_lut();
    logic [63:0]  t;
    logic [63:0]  term;
    logic [63:0]  r;
    logic [63:0]  p;
    logic [127:0] w;
    t    = (64'd16 << 32) / EXP_TABLE_SIZE;
    term = 64'd1 << 32;
    r    = term;
    p    = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      w    = {64'd0, term} * {64'd0, t};
      term = w[95:32] / n;
      if (n[0]) r = r - term;
      else r = r + term;
    end
    for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
      w          = {64'd0, p} + 128'h8000;
      exp_lut[k] = w[32:16];
      w          = {64'd0, p} * {64'd0, r} + (128'd1 << 31);
      p          = w[95:32];
    end
  endtask

  function automatic logic [31:0] exp_of(logic signed [31:0] d);
    logic [31:0] nd;
    nd = -d;
    if (nd > 16384) return 0;
    return exp_lut[(64'(nd) * EXP_TABLE_SIZE) / 16384];
  endfunction

  // closes the column and queues one result per stored element
  task automatic close_column(logic func);
    logic [31:0]        total;
    logic [31:0]        e;
    logic [63:0]        q;
    logic signed [63:0] diff;
    logic signed [63:0] g;
    result_t            res;
    total = 0;
    if (func == FUNC_FWD) begin
      for (int i = 0; i < col_len; i++)
        total += exp_of(32'($signed(col_val[i])) - 32'(col_max));
    end
    for (int i = 0; i < col_len; i++) begin
      res = '0;
      res.last = (i + 1 == col_len);
      if (func == FUNC_FWD) begin
        e = exp_of(32'($signed(col_val[i])) - 32'(col_max));
        q = 0;
        if (total != 0) q = ((64'(e) << 16) + total / 2) / total;
        if (q > 65535) q = 65535;
        res.prob = q[15:0];
      end else begin
        diff = 64'($signed(col_grad[i])) * 65536 - col_dot;
        g = ($signed({48'd0, col_val[i]}) * diff + (64'sd1 <<< 31)) >>> 32;
        if (g > 32767) g = 32767;
        if (g < -32768) g = -32768;
        res.grad = g[15:0];
      end
      expected_q.push_back(res);
    end
    col_len = 0;
    col_max = -16'sd32768;
    col_dot = 0;
  endtask

  task automatic predict_element(logic func, logic [15:0] logit, logic [15:0] prob,
                                 logic [15:0] grad, logic last);
    logic [15:0] v;
    v = func ? prob : logit;
    col_val[col_len]  = v;
    col_grad[col_len] = grad;
    if ($signed(v) > col_max) col_max = $signed(v);
    col_dot += $signed({48'd0, v}) * 64'($signed(grad));
    col_len++;
    if (last || col_len == MAX_LEN) close_column(func);
  endtask

  task automatic send_element(logic func, logic [15:0] logit, logic [15:0] prob,
                              logic [15:0] grad, logic last);
    int gap;
    if (!src_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {grad, prob, logit};
    in_tuser  <= func;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_element(func, logit, prob, grad, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[15:0], 16'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[15:0] !== want.prob) report_mismatch("out_prob", out_tdata[15:0], want.prob);
        if (out_tdata[31:16] !== want.grad) report_mismatch("out_grad", out_tdata[31:16], want.grad);
        if (out_tlast !== want.last) report_mismatch("out_last", 16'(out_tlast), 16'(want.last));
      end
    end
  end

  // result side backpressure
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (!sink_idle && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_column(logic func, int len, bit rand_fields);
    logic [15:0] z, a, f;
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: z = 16'($urandom);
        1: z = 16'(base - $urandom_range(0, 20000));
        default: z = 16'(base - $urandom_range(0, 4000));
      endcase
      a = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 65536 / len));
      f = 16'($urandom);
      if (!rand_fields) begin z = 16'(i * 1000); a = 16'(65536 / len); f = 16'(i * 256); end
      send_element(func, z, a, f, (i == len - 1) && (len < MAX_LEN || $urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    send_element(FUNC_FWD, 16'h7fff, 16'h0, 16'h0, 1'b1);
    send_element(FUNC_FWD, 16'h8000, 16'h0, 16'h0, 1'b0);
    send_element(FUNC_FWD, 16'h7fff, 16'h0, 16'h0, 1'b1);
    send_element(FUNC_FWD, 16'h0000, 16'h0, 16'h0, 1'b0);
    send_element(FUNC_FWD, 16'hc000, 16'h0, 16'h0, 1'b0);
    send_element(FUNC_FWD, 16'hbfff, 16'h0, 16'h0, 1'b1);
    send_element(FUNC_BWD, 16'h0, 16'hffff, 16'h7fff, 1'b0);
    send_element(FUNC_BWD, 16'h0, 16'hffff, 16'h8000, 1'b1);
    send_element(FUNC_BWD, 16'h0, 16'h0000, 16'h8000, 1'b1);
    // mixed func within one column
    send_element(FUNC_BWD, 16'h1234, 16'h8000, 16'h0400, 1'b0);
    send_element(FUNC_FWD, 16'hfc00, 16'hffff, 16'hfc00, 1'b1);
    send_element(FUNC_FWD, 16'h0400, 16'h0, 16'h0400, 1'b0);
    send_element(FUNC_BWD, 16'h0, 16'hc000, 16'h8000, 1'b1);
    send_column(FUNC_FWD, 5, 1'b0);
    send_column(FUNC_BWD, 4, 1'b0);
    wait_drained();
  endtask

  task automatic test_full_column();
    send_column(FUNC_FWD, MAX_LEN, 1'b1);
    send_column(FUNC_BWD, MAX_LEN, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    send_column(FUNC_BWD, 40, 1'b1);
    send_column(FUNC_FWD, 30, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int items, bit quiet);
    int sent;
    int len;
    sent = 0;
    src_idle  = quiet;
    sink_idle = quiet;
    while (sent < items) begin
      len = $urandom_range(0, 7) == 0 ? $urandom_range(1, MAX_LEN) : $urandom_range(1, 8);
      send_column(1'($urandom_range(0, 1)), len, 1'b1);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    error_count = 0;
    sink_idle   = 1'b0;
    src_idle    = 1'b0;
    hold_cycles = 0;
    col_len     = 0;
    col_max     = -16'sd32768;
    col_dot     = 0;
    build_exp_lut();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_column();
    test_backpressure();
    test_random(140, 1'b0);
    test_random(40, 1'b1);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
